@@ rtl/pei_pkg.sv @@
// ----------------------------------------------------------------------------
// pei_pkg
// Types and codes shared by the ellipse union tester: command codes, the
// stored ellipse entry, control states and the test unit status.
// ----------------------------------------------------------------------------
`default_nettype none

package pei_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [14:0]        w;
		logic [14:0]        h;
	} ellipse_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic hit;
		logic busy;
	} test_stat_t;

endpackage

`default_nettype wire

@@ rtl/pei_in_if.sv @@
// ----------------------------------------------------------------------------
// pei_in_if
// Command channel: valid/ready handshake with command and operand payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface pei_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [14:0]        full_width;
	logic [14:0]        full_height;

	modport source (
		output valid, command, pos_x, pos_y, full_width, full_height,
		input  ready
	);
	modport sink (
		input  valid, command, pos_x, pos_y, full_width, full_height,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/pei_out_if.sv @@
// ----------------------------------------------------------------------------
// pei_out_if
// Result channel: valid/ready handshake carrying the query answer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pei_out_if;
	logic valid;
	logic ready;
	logic covered;
	logic dropped_any;

	modport source (
		output valid, covered, dropped_any,
		input  ready
	);
	modport sink (
		input  valid, covered, dropped_any,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/point_in_ellipse_union.sv @@
// ----------------------------------------------------------------------------
// point_in_ellipse_union
// Tests whether a point lies in the union of stored axis-aligned ellipses.
// ----------------------------------------------------------------------------
// Clear and add commands complete in the cycle they are accepted. In a
// query the stored ellipses sit in a ring of cells that rotates one step a
// cycle past a single four-stage multiply-compare pipeline; once the ring
// has gone round and the pipeline has drained, the result is loaded into
// the output register as soon as that is free. The scan waits only for
// live tests still in the pipeline, so when the last ring positions hold no
// entry, or a zero-size or far-off one, the result comes sooner. The next
// command is taken once the result is in the output register, even while
// that result waits to be read. Adds beyond MAX_ELLIPSES entries are dropped
// and set the sticky dropped_any flag, which a clear resets. No clearing pass
// runs after reset.
`default_nettype none

module point_in_ellipse_union
	import pei_pkg::*;
#(
	parameter int MAX_ELLIPSES = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pei_in_if.sink    req,
	pei_out_if.source rsp
);

	localparam int CW = $clog2(MAX_ELLIPSES + 1);
	localparam int IW = (MAX_ELLIPSES > 1) ? $clog2(MAX_ELLIPSES) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELLIPSES);

	state_t             state_q;
	state_t             state_nxt;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      step_q;
	logic               ovf_q;
	logic               acc_q;
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	logic               out_valid_q;
	logic               covered_q;
	logic               dropped_q;

	logic       accept;
	logic       do_clear;
	logic       do_add;
	logic       do_query;
	logic       issue;
	logic       load_out;
	ellipse_t   new_ent;
	ellipse_t   cell_q [MAX_ELLIPSES];
	test_stat_t stat;

	assign accept   = req.valid && req.ready;
	assign do_clear = accept && (req.command == CMD_CLEAR);
	assign do_add   = accept && (req.command == CMD_ADD);
	assign do_query = accept && (req.command == CMD_QUERY);

	assign new_ent.cx = req.pos_x;
	assign new_ent.cy = req.pos_y;
	assign new_ent.w  = req.full_width;
	assign new_ent.h  = req.full_height;

	// ring of cells, cell 0 feeds the test pipeline
	for (genvar i = 0; i < MAX_ELLIPSES; i++) begin : g_cell
		pei_cell u_cell (
			.clk   (clk),
			.load  (do_add && (count_q < MAX_CNT) && (count_q[IW-1:0] == IW'(i))),
			.shift (issue),
			.din   (new_ent),
			.nbr   (cell_q[(i + 1) % MAX_ELLIPSES]),
			.q     (cell_q[i])
		);
	end

	pei_test u_test (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue && (step_q < count_q)),
		.ent    (cell_q[0]),
		.pos_x  (px_q),
		.pos_y  (py_q),
		.stat   (stat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (do_query) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((step_q == MAX_CNT) && !stat.busy) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: issue     = (step_q < MAX_CNT);
			ST_DONE: load_out  = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			ovf_q       <= 1'b0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (do_clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (do_add) begin
				if (count_q < MAX_CNT) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (do_query) begin
				step_q <= '0;
				acc_q  <= 1'b0;
			end else begin
				if (issue) begin
					step_q <= step_q + CW'(1);
				end
				if (stat.hit) begin
					acc_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_query) begin
			px_q <= req.pos_x;
			py_q <= req.pos_y;
		end
		if (load_out) begin
			covered_q <= acc_q;
			dropped_q <= ovf_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.covered     = covered_q;
	assign rsp.dropped_any = dropped_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("entry count beyond table size");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= MAX_CNT)
		else $error("scan step beyond ring length");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !stat.busy)
		else $error("test pipeline still busy when result is loaded");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> state_q == ST_SCAN)
		else $error("hit outside a scan");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do_clear |=> (count_q == '0) && !ovf_q)
		else $error("clear did not empty the table");
`endif

endmodule

`default_nettype wire

@@ rtl/pei_cell.sv @@
// ----------------------------------------------------------------------------
// pei_cell
// One storage cell of the ellipse ring. Loads a new entry on an add and
// takes its neighbour's entry on every rotation step of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module pei_cell
	import pei_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     load,
	input  wire logic     shift,
	input  wire ellipse_t din,
	input  wire ellipse_t nbr,
	output ellipse_t      q
);

	ellipse_t ent_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= din;
		end else if (shift) begin
			ent_q <= nbr;
		end
	end

	assign q = ent_q;

endmodule

`default_nettype wire

@@ rtl/pei_test.sv @@
// ----------------------------------------------------------------------------
// pei_test
// Shared multiply-compare pipeline. Tests one ellipse per cycle against the
// query point with (2dx*h)^2 + (2dy*w)^2 <= (w*h)^2, four stages deep.
// ----------------------------------------------------------------------------
`default_nettype none

module pei_test
	import pei_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               issue,
	input  wire ellipse_t           ent,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	output test_stat_t              stat
);

	logic [16:0] dx;
	logic [16:0] dy;
	logic [16:0] ndx;
	logic [16:0] ndy;
	logic [15:0] adx;
	logic [15:0] ady;

	logic        v_s1;
	logic [16:0] tdx_s1;
	logic [16:0] tdy_s1;
	logic [14:0] w_s1;
	logic [14:0] h_s1;

	logic        in_rng;
	logic        v_s2;
	logic [29:0] a_s2;
	logic [29:0] b_s2;
	logic [29:0] c_s2;

	logic        v_s3;
	logic [59:0] a2_s3;
	logic [59:0] b2_s3;
	logic [59:0] c2_s3;

	logic [60:0] lhs;

	// stage 1: absolute offsets, doubled
	assign dx  = {pos_x[15], pos_x} - {ent.cx[15], ent.cx};
	assign dy  = {pos_y[15], pos_y} - {ent.cy[15], ent.cy};
	assign ndx = 17'd0 - dx;
	assign ndy = 17'd0 - dy;
	assign adx = dx[16] ? ndx[15:0] : dx[15:0];
	assign ady = dy[16] ? ndy[15:0] : dy[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			// degenerate ellipses never cover anything
			v_s1 <= issue && (ent.w != 15'd0) && (ent.h != 15'd0);
			v_s2 <= v_s1 && in_rng;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tdx_s1 <= {adx, 1'b0};
		tdy_s1 <= {ady, 1'b0};
		w_s1   <= ent.w;
		h_s1   <= ent.h;
	end

	// stage 2: outside the bounding box is a miss, else the cross products
	assign in_rng = (tdx_s1 <= {2'b00, w_s1}) && (tdy_s1 <= {2'b00, h_s1});

	always_ff @(posedge clk) begin
		a_s2 <= tdx_s1[14:0] * h_s1;
		b_s2 <= tdy_s1[14:0] * w_s1;
		c_s2 <= w_s1 * h_s1;
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		a2_s3 <= a_s2 * a_s2;
		b2_s3 <= b_s2 * b_s2;
		c2_s3 <= c_s2 * c_s2;
	end

	// stage 4: sum and compare, registered by the caller
	assign lhs       = {1'b0, a2_s3} + {1'b0, b2_s3};
	assign stat.hit  = v_s3 && (lhs <= {1'b0, c2_s3});
	assign stat.busy = v_s1 || v_s2 || v_s3;

endmodule

`default_nettype wire

@@ bench/tb_point_in_ellipse_union.sv @@
// ----------------------------------------------------------------------------
// tb_point_in_ellipse_union
// Self-checking bench for the ellipse union tester. Commands are generated up
// front into a queue: a short directed list (empty table, zero-size shapes,
// corner shapes, boundary and far points, table overflow, spare code), then
// random sessions of clears, adds, spare codes and mostly targeted queries.
// A clocked driver feeds the command channel with random gaps. A clocked
// monitor mirrors the table on every accepted command, works out the query
// answer and checks each result beat against the oldest pending answer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_in_ellipse_union;
	import pei_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TABLE_DEPTH = 16;
	localparam int          TARGET_CMDS = 800;
	localparam int          CALM_TAIL   = 100;
	localparam int          HOLD_CYCLES = 400;
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [1:0]  CMD_SPARE   = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		bit                 settle;
	} beat_t;

	typedef struct {
		logic covered;
		logic dropped_any;
	} answer_t;

	logic clk;
	logic arst_n;

	pei_in_if  req ();
	pei_out_if rsp ();

	point_in_ellipse_union #(
		.MAX_ELLIPSES(TABLE_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	beat_t    cmd_q[$];
	answer_t  answer_q[$];
	ellipse_t shape_tab[TABLE_DEPTH];
	int       shape_cnt;
	logic     spill_flag;

	int  taken_cnt;
	int  total_cmds;
	int  fail_cnt;
	int  cycle_cnt;
	bit  took_beat;
	bit  calm;
	bit  hold_off;
	int  send_gap;
	int  ready_gap;

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	// exact integer ellipse test, with the far-offset early out
	function automatic bit shape_covers(ellipse_t e, logic signed [15:0] px,
	                                    logic signed [15:0] py);
		longint unsigned tdx, tdy, lw, lh;
		int dx, dy;
		if (e.w == 0 || e.h == 0)
			return 1'b0;
		dx = int'(px) - int'(e.cx);
		dy = int'(py) - int'(e.cy);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		tdx = 2 * longint'(dx);
		tdy = 2 * longint'(dy);
		lw  = e.w;
		lh  = e.h;
		if (tdx > lw || tdy > lh)
			return 1'b0;
		return tdx * tdx * lh * lh + tdy * tdy * lw * lw <= lw * lw * lh * lh;
	endfunction

	task automatic push_cmd(logic [1:0] op, int x, int y, int w, int h, bit settle);
		beat_t b;
		b.op     = op;
		b.x      = 16'(x);
		b.y      = 16'(y);
		b.w      = 15'(w);
		b.h      = 15'(h);
		b.settle = settle;
		cmd_q.insert(cmd_q.size(), b);
	endtask

	function automatic int rand_span();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 32767;
			2, 3, 4: return $urandom_range(1, 64);
			5:       return $urandom_range(1, 1024);
			default: return $urandom_range(1, 32767);
		endcase
	endfunction

	// driver: new beat on the falling edge once the previous one is taken
	always @(negedge clk) begin : drive
		beat_t b;
		if (arst_n && (!req.valid || took_beat)) begin
			if (send_gap > 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (cmd_q.size() > 0 && !(cmd_q[0].settle && answer_q.size() > 0)) begin
				b = cmd_q.pop_front();
				req.valid       <= 1'b1;
				req.command     <= b.op;
				req.pos_x       <= b.x;
				req.pos_y       <= b.y;
				req.full_width  <= b.w;
				req.full_height <= b.h;
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 19);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver stalls, plus the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_gap > 0)
				ready_gap--;
			else if (!calm && $urandom_range(0, 7) == 0)
				ready_gap = $urandom_range(1, 19);
			rsp.ready <= !hold_off && ready_gap == 0;
		end
	end

	initial begin
		hold_off = 1'b0;
		while (taken_cnt < 150)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// monitor: mirror the table on each command beat, check each result beat
	always @(posedge clk) begin : watch
		beat_t   b;
		answer_t a;
		answer_t want;
		took_beat = arst_n && req.valid && req.ready;
		if (took_beat) begin
			taken_cnt++;
			if (taken_cnt >= total_cmds - CALM_TAIL)
				calm = 1'b1;
			b.op = req.command;
			b.x  = req.pos_x;
			b.y  = req.pos_y;
			b.w  = req.full_width;
			b.h  = req.full_height;
			case (b.op)
				CMD_CLEAR: begin
					shape_cnt  = 0;
					spill_flag = 1'b0;
				end
				CMD_ADD: begin
					if (shape_cnt < TABLE_DEPTH) begin
						shape_tab[shape_cnt] = '{cx: b.x, cy: b.y, w: b.w, h: b.h};
						shape_cnt++;
					end else begin
						spill_flag = 1'b1;
					end
				end
				CMD_QUERY: begin
					a.covered     = 1'b0;
					a.dropped_any = spill_flag;
					for (int i = 0; i < shape_cnt; i++)
						if (shape_covers(shape_tab[i], b.x, b.y))
							a.covered = 1'b1;
					answer_q.insert(answer_q.size(), a);
				end
				default: ;
			endcase
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (answer_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("[%0t] result beat with no query pending: covered=%0b dropped_any=%0b",
					         $realtime, rsp.covered, rsp.dropped_any);
			end else begin
				want = answer_q.pop_front();
				if (rsp.covered !== want.covered || rsp.dropped_any !== want.dropped_any) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("[%0t] mismatch: covered exp %0b got %0b, dropped_any exp %0b got %0b",
						         $realtime, want.covered, rsp.covered, want.dropped_any,
						         rsp.dropped_any);
				end
			end
		end
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : run
		ellipse_t kept[$];
		ellipse_t s;
		int       n_cmds;
		int       n_add;
		int       n_ask;
		int       session;
		int       ox;
		int       oy;
		int       w;
		int       h;

		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.command     = CMD_CLEAR;
		req.pos_x       = '0;
		req.pos_y       = '0;
		req.full_width  = '0;
		req.full_height = '0;
		rsp.ready       = 1'b0;
		took_beat       = 1'b0;
		calm            = 1'b0;
		send_gap        = 0;
		ready_gap       = 0;
		taken_cnt       = 0;
		fail_cnt        = 0;
		cycle_cnt       = 0;
		shape_cnt       = 0;
		spill_flag      = 1'b0;
		total_cmds      = 1 << 30;

		// directed part
		push_cmd(CMD_QUERY, -32768, 32767, 32767, 32767, 0);   // empty table
		push_cmd(CMD_SPARE, -1, -1, 32767, 32767, 0);          // ignored code
		push_cmd(CMD_ADD, 0, 0, 0, 10, 0);                     // zero width
		push_cmd(CMD_ADD, 0, 0, 10, 0, 0);                     // zero height
		push_cmd(CMD_QUERY, 0, 0, 0, 0, 0);                    // own centre, not covered
		push_cmd(CMD_ADD, -32768, -32768, 32767, 32767, 0);
		push_cmd(CMD_QUERY, -32768, -32768, 0, 0, 0);
		push_cmd(CMD_QUERY, -32768 + 16383, -32768, 0, 0, 0);  // just inside the rim
		push_cmd(CMD_ADD, 32767, 32767, 2, 2, 0);
		push_cmd(CMD_QUERY, 32766, 32767, 0, 0, 0);            // on the rim
		push_cmd(CMD_QUERY, 32766, 32766, 0, 0, 0);            // just outside
		push_cmd(CMD_QUERY, 32767, -32768, 1, 1, 0);           // far offsets
		for (int i = 0; i < TABLE_DEPTH - 4; i++)
			push_cmd(CMD_ADD, $urandom, $urandom, rand_span(), rand_span(), 0);
		push_cmd(CMD_ADD, 5, 5, 100, 100, 0);                  // table full, dropped
		push_cmd(CMD_QUERY, 5, 5, 0, 0, 0);
		push_cmd(CMD_CLEAR, -1, -1, 32767, 32767, 0);
		push_cmd(CMD_QUERY, 0, 0, 0, 0, 1);                    // after a drain

		// random sessions
		n_cmds  = 0;
		session = 0;
		while (n_cmds < TARGET_CMDS) begin
			session++;
			if ($urandom_range(0, 3) != 0) begin
				push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, session == 25);
				n_cmds++;
				kept.delete();
			end
			n_add = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
			for (int i = 0; i < n_add; i++) begin
				w = rand_span();
				h = rand_span();
				s = '{cx: 16'($urandom), cy: 16'($urandom), w: 15'(w), h: 15'(h)};
				kept.insert(kept.size(), s);
				push_cmd(CMD_ADD, s.cx, s.cy, w, h, 0);
				n_cmds++;
			end
			n_ask = $urandom_range(2, 10);
			for (int i = 0; i < n_ask; i++) begin
				case ($urandom_range(0, 9))
					0: begin
						push_cmd(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, 0);
						n_cmds++;
					end
					1: push_cmd(CMD_SPARE, $urandom, $urandom, $urandom, $urandom, 0);
					default: begin
						// aim near a shape added since the last clear, straddling its rim
						s  = kept[$urandom_range(0, kept.size() - 1)];
						ox = int'($urandom_range(0, s.w + 2)) - int'(s.w / 2) - 1;
						oy = int'($urandom_range(0, s.h + 2)) - int'(s.h / 2) - 1;
						if ($urandom_range(0, 3) == 0)
							oy = 0;
						push_cmd(CMD_QUERY, int'(s.cx) + ox, int'(s.cy) + oy,
						         $urandom, $urandom, 0);
						n_cmds++;
					end
				endcase
			end
		end
		total_cmds = cmd_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_q.size() > 0 || req.valid)
			@(posedge clk);
		while (answer_q.size() > 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 20) @(posedge clk);

		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/pei_pkg.sv
rtl/pei_in_if.sv
rtl/pei_out_if.sv
rtl/pei_cell.sv
rtl/pei_test.sv
rtl/point_in_ellipse_union.sv
bench/tb_point_in_ellipse_union.sv
